// ===== hdl/shs_pkg.sv =====
// Package for the stick heading smoother: register indexes, reset values,
// widths of the serial multiplier and the CORDIC, and the arctangent table.
// No dependencies.
package shs_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int ITER_W = $clog2(CORDIC_ITERS + 1);

  localparam int MUL_BITS = 17;
  localparam int MUL_CNT_W = $clog2(MUL_BITS + 1);

  localparam int CORD_W = 28;
  localparam int Z_W = 26;
  localparam int HALF_TURN = 23040;
  localparam int FULL_TURN = 46080;

  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90 * 65536);

  localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [1:0] REG_MIN_HOLD = 2'd1;
  localparam logic [1:0] REG_ACTIVE_BLEND = 2'd2;
  localparam logic [1:0] REG_RETURN_BLEND = 2'd3;

  localparam logic [14:0] DEAD_ZONE_RESET = 15'd8192;
  localparam logic [23:0] MIN_HOLD_RESET = 24'd250000;
  localparam logic [16:0] ACTIVE_BLEND_RESET = 17'd6554;
  localparam logic [16:0] RETURN_BLEND_RESET = 17'd3277;

  // Arctangent of 2^-i in units of 1/65536 degree.
  function automatic logic [21:0] atan_of(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0: v = 22'd2949120;
      5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;
      5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;
      5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/shs_sermul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on shs_pkg for the operand width.
module shs_sermul import shs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [MUL_BITS-1:0]     op_a,
  input  logic [MUL_BITS-1:0]     op_b,
  output logic                    busy,
  output logic [2*MUL_BITS-1:0]   product
);

  logic [2*MUL_BITS-1:0] mcand;
  logic [MUL_BITS-1:0]   mplier;
  logic [MUL_CNT_W-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      mcand <= {{MUL_BITS{1'b0}}, op_a};
      mplier <= op_b;
      product <= '0;
      cnt <= MUL_CNT_W'(MUL_BITS);
      busy <= 1'b1;
    end else if (busy) begin
      if (mplier[0]) begin
        product <= product + mcand;
      end
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
      cnt <= cnt - 1'b1;
      if (cnt == MUL_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/stick_heading_smoother.sv =====
// Top level of the stick heading smoother: sequencer, iterative CORDIC,
// three serial multipliers and the angle update. Depends on shs_pkg and shs_sermul.
//
//   channel  signals                                       direction
//   in       in_valid, in_ready, stick_x, stick_y,         into block
//            elapsed_us, paused
//   out      out_valid, out_ready, view_angle, is_rotated  out of block
//   cfg      cfg_we, cfg_index, cfg_data                   into block
//
// A sample runs from acceptance to a registered result in order: the serial squares
// finish (the CORDIC runs beside them), three steps follow (head, decide, load), then
// the serial blend multiply and three more steps for rounding, wrap and output.
// A release tick skips the blend. After the return to idle a new sample can follow;
// none is taken while one is in flight. The multiplier width sets both serial
// phases. Reset is synchronous and restores the register defaults. A stalled
// result holds in the output register; a new sample is taken once the previous
// one has left the pipeline and the finished result has been handed over or registered.
module stick_heading_smoother import shs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic [15:0]        elapsed_us,
  input  logic               paused,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] view_angle,
  output logic               is_rotated
);

  typedef enum logic [3:0] {
    S_IDLE, S_RUN, S_HEAD, S_DECIDE, S_LOAD, S_MUL, S_APPLY, S_WRAP, S_FINISH
  } state_t;

  localparam logic signed [17:0] HALF_D = 18'(HALF_TURN);
  localparam logic signed [17:0] FULL_D = 18'(FULL_TURN);
  localparam logic signed [20:0] HALF_A = 21'(HALF_TURN);
  localparam logic signed [20:0] FULL_A = 21'(FULL_TURN);

  state_t state;

  logic [14:0] dead_zone_radius;
  logic [23:0] min_hold_time;
  logic [16:0] active_blend;
  logic [16:0] return_blend;

  logic [23:0]        hold_timer;
  logic               rotated_flag;
  logic signed [16:0] held_heading;
  logic signed [15:0] current_angle;

  logic               paused_r;
  logic               zero_r;
  logic               pass_r;
  logic               use_active;
  logic               dneg;
  logic signed [16:0] heading_r;
  logic signed [17:0] diff;
  logic signed [19:0] step;

  logic signed [CORD_W-1:0] ca;
  logic signed [CORD_W-1:0] cb;
  logic signed [Z_W-1:0]    cz;
  logic [ITER_W-1:0]        cordic_cnt;

  logic [MUL_BITS-1:0]   mul_a [3];
  logic [MUL_BITS-1:0]   mul_b [3];
  logic                  mul_start [3];
  logic                  mul_busy [3];
  logic [2*MUL_BITS-1:0] mul_p [3];

  logic                     accept;
  logic                     cordic_done;
  logic                     mul_idle;
  logic signed [16:0]       x_ext;
  logic signed [16:0]       y_ext;
  logic [MUL_BITS-1:0]      x_abs;
  logic [MUL_BITS-1:0]      y_abs;
  logic signed [CORD_W-1:0] a_pre;
  logic signed [CORD_W-1:0] b_pre;
  logic signed [CORD_W-1:0] a_init;
  logic signed [CORD_W-1:0] b_init;
  logic signed [Z_W-1:0]    z_init;
  logic signed [CORD_W-1:0] sa;
  logic signed [CORD_W-1:0] sb;
  logic signed [Z_W-1:0]    z_step;
  logic signed [Z_W-1:0]    z_round;
  logic [24:0]              timer_sum;
  logic [2*MUL_BITS:0]      mag_sum;
  logic                     release_now;
  logic signed [16:0]       target;
  logic signed [17:0]       dw;
  logic [MUL_BITS-1:0]      dw_abs;
  logic signed [35:0]       prod_ext;
  logic signed [35:0]       prod_rnd;
  logic signed [20:0]       angle_sum;
  logic signed [20:0]       angle_wrap;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign cordic_done = (cordic_cnt == ITER_W'(CORDIC_ITERS));
  assign mul_idle = !mul_busy[0] && !mul_busy[1] && !mul_busy[2];

  always_comb begin
    x_ext = {stick_x[15], stick_x};
    y_ext = {stick_y[15], stick_y};
    x_abs = x_ext[16] ? MUL_BITS'(-x_ext) : MUL_BITS'(x_ext);
    y_abs = y_ext[16] ? MUL_BITS'(-y_ext) : MUL_BITS'(y_ext);

    a_pre = {{(CORD_W - 24){stick_y[15]}}, stick_y, 8'd0};
    b_pre = {{(CORD_W - 24){stick_x[15]}}, stick_x, 8'd0};
    if (a_pre[CORD_W-1]) begin
      if (!b_pre[CORD_W-1]) begin
        a_init = b_pre;
        b_init = -a_pre;
        z_init = Z_QUARTER;
      end else begin
        a_init = -b_pre;
        b_init = a_pre;
        z_init = -Z_QUARTER;
      end
    end else begin
      a_init = a_pre;
      b_init = b_pre;
      z_init = '0;
    end

    sa = ca >>> cordic_cnt;
    sb = cb >>> cordic_cnt;
    z_step = {{(Z_W - 22){1'b0}}, atan_of(5'(cordic_cnt))};
    z_round = cz + Z_W'(256);

    timer_sum = {1'b0, hold_timer} + {9'd0, elapsed_us};
    mag_sum = {1'b0, mul_p[0]} + {1'b0, mul_p[1]};

    release_now = !pass_r && rotated_flag && !paused_r && (hold_timer > min_hold_time);
    if (pass_r) begin
      target = heading_r;
    end else if (rotated_flag) begin
      target = held_heading;
    end else begin
      target = '0;
    end

    if (diff > HALF_D) begin
      dw = diff - FULL_D;
    end else if (diff <= -HALF_D) begin
      dw = diff + FULL_D;
    end else begin
      dw = diff;
    end
    dw_abs = dw[17] ? MUL_BITS'(-dw) : MUL_BITS'(dw);

    prod_ext = {2'b00, mul_p[0]};
    prod_rnd = (dneg ? -prod_ext : prod_ext) + 36'sd32768;

    angle_sum = {{5{current_angle[15]}}, current_angle} + {step[19], step};
    if (angle_sum > HALF_A) begin
      angle_wrap = angle_sum - FULL_A;
    end else if (angle_sum <= -HALF_A) begin
      angle_wrap = angle_sum + FULL_A;
    end else begin
      angle_wrap = angle_sum;
    end

    mul_a[0] = (state == S_LOAD) ? dw_abs : x_abs;
    mul_b[0] = (state == S_LOAD) ? (use_active ? active_blend : return_blend) : x_abs;
    mul_start[0] = accept || (state == S_LOAD);
    mul_a[1] = y_abs;
    mul_b[1] = y_abs;
    mul_start[1] = accept;
    mul_a[2] = {2'b00, dead_zone_radius};
    mul_b[2] = {2'b00, dead_zone_radius};
    mul_start[2] = accept;
  end

  shs_sermul u_mul_x (
    .clk(clk), .rst(rst), .start(mul_start[0]), .op_a(mul_a[0]), .op_b(mul_b[0]),
    .busy(mul_busy[0]), .product(mul_p[0])
  );

  shs_sermul u_mul_y (
    .clk(clk), .rst(rst), .start(mul_start[1]), .op_a(mul_a[1]), .op_b(mul_b[1]),
    .busy(mul_busy[1]), .product(mul_p[1])
  );

  shs_sermul u_mul_r (
    .clk(clk), .rst(rst), .start(mul_start[2]), .op_a(mul_a[2]), .op_b(mul_b[2]),
    .busy(mul_busy[2]), .product(mul_p[2])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dead_zone_radius <= DEAD_ZONE_RESET;
      min_hold_time <= MIN_HOLD_RESET;
      active_blend <= ACTIVE_BLEND_RESET;
      return_blend <= RETURN_BLEND_RESET;
      hold_timer <= '0;
      rotated_flag <= 1'b0;
      held_heading <= '0;
      current_angle <= '0;
      cordic_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEAD_ZONE: dead_zone_radius <= cfg_data[14:0];
          REG_MIN_HOLD: min_hold_time <= cfg_data;
          REG_ACTIVE_BLEND: active_blend <= cfg_data[16:0];
          REG_RETURN_BLEND: return_blend <= cfg_data[16:0];
        endcase
      end

      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            paused_r <= paused;
            zero_r <= (stick_x == '0) && (stick_y == '0);
            hold_timer <= timer_sum[24] ? '1 : timer_sum[23:0];
            ca <= a_init;
            cb <= b_init;
            cz <= z_init;
            cordic_cnt <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!cordic_done) begin
            if (!cb[CORD_W-1]) begin
              ca <= ca + sb;
              cb <= cb - sa;
              cz <= cz + z_step;
            end else begin
              ca <= ca - sb;
              cb <= cb + sa;
              cz <= cz - z_step;
            end
            cordic_cnt <= cordic_cnt + 1'b1;
          end else if (mul_idle) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          pass_r <= (mag_sum >= {1'b0, mul_p[2]});
          heading_r <= zero_r ? 17'sd0 : 17'(z_round >>> 9);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          diff <= {target[16], target} - {{2{current_angle[15]}}, current_angle};
          use_active <= pass_r || rotated_flag;
          if (pass_r) begin
            if (!rotated_flag) begin
              hold_timer <= '0;
              rotated_flag <= 1'b1;
            end
            held_heading <= heading_r;
            state <= S_LOAD;
          end else if (release_now) begin
            rotated_flag <= 1'b0;
            held_heading <= '0;
            state <= S_FINISH;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          dneg <= dw[17];
          state <= S_MUL;
        end
        S_MUL: begin
          if (!mul_busy[0]) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          step <= 20'(prod_rnd >>> 16);
          state <= S_WRAP;
        end
        S_WRAP: begin
          current_angle <= 16'(angle_wrap);
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            view_angle <= current_angle;
            is_rotated <= rotated_flag;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("sample accepted while a previous sample was still in flight");

  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && (!out_valid || out_ready) |=> out_valid && in_ready)
    else $error("finished result was not registered");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (view_angle > -16'sd23040) && (view_angle <= 16'sd23040))
    else $error("view angle outside the half-open turn");

  a_held_cleared: assert property (@(posedge clk) disable iff (rst)
    !rotated_flag |-> held_heading == 17'sd0)
    else $error("held heading kept while not rotated");

  a_idle_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> mul_idle)
    else $error("multiplier busy while idle");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stick_heading_smoother: a directed table, then random joystick
// gestures under several register settings and handshake idling patterns.
// Depends on shs_pkg and the RTL of the block; results are checked by a built-in predictor.
module testbench;
  import shs_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam longint HALF = 23040;
  localparam longint FULL = 46080;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               rotated;
  } view_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         index;
    logic [23:0]        data;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        dt;
    logic               pause;
    logic               pinned;
    view_t              view;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_DEAD_ZONE;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] stick_x = '0;
  logic signed [15:0] stick_y = '0;
  logic [15:0]        elapsed_us = '0;
  logic               paused = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] view_angle;
  logic               is_rotated;

  stick_heading_smoother uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stick_x(stick_x),
    .stick_y(stick_y),
    .elapsed_us(elapsed_us),
    .paused(paused),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .view_angle(view_angle),
    .is_rotated(is_rotated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  longint atan_deg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic [14:0] dz_reg = DEAD_ZONE_RESET;
  logic [23:0] hold_reg = MIN_HOLD_RESET;
  logic [16:0] active_reg = ACTIVE_BLEND_RESET;
  logic [16:0] return_reg = RETURN_BLEND_RESET;

  logic [23:0] hold_timer = '0;
  logic        rotated = 1'b0;
  longint      held = 0;
  longint      angle_now = 0;

  view_t view_queue [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  row_t directed [26];

  function automatic longint wrap_turn(input longint d);
    longint r;
    r = d % FULL;
    if (r > HALF) r -= FULL;
    if (r <= -HALF) r += FULL;
    return r;
  endfunction

  // Vectoring CORDIC; the accumulator is in 1/65536 degree from straight up.
  function automatic longint stick_heading(input longint x, input longint y);
    longint a, b, z, t, sa, sb;
    a = y * 256;
    b = x * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (a < 0) begin
      if (b >= 0) begin
        t = a; a = b; b = -t; z = 90 * 65536;
      end else begin
        t = a; a = -b; b = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      sa = a >>> i;
      sb = b >>> i;
      if (b >= 0) begin
        a = a + sb; b = b - sa; z += atan_deg[i];
      end else begin
        a = a - sb; b = b + sa; z -= atan_deg[i];
      end
    end
    return (z + 256) >>> 9;
  endfunction

  task automatic advance_view(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic [15:0] dt, input logic pause, output view_t v);
    longint mag2, r, target, delta, blend;
    logic [24:0] sum;
    logic release_tick;
    sum = {1'b0, hold_timer} + {9'd0, dt};
    hold_timer = (sum > 25'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
    mag2 = longint'(x) * longint'(x) + longint'(y) * longint'(y);
    r = longint'(dz_reg);
    release_tick = 1'b0;
    if (mag2 >= r * r) begin
      if (!rotated) begin
        hold_timer = '0;
        rotated = 1'b1;
      end
      held = stick_heading(longint'(x), longint'(y));
    end else if (rotated && !pause && hold_timer > hold_reg) begin
      rotated = 1'b0;
      held = 0;
      release_tick = 1'b1;
    end
    if (!release_tick) begin
      target = rotated ? held : 0;
      delta = wrap_turn(target - angle_now);
      blend = rotated ? longint'(active_reg) : longint'(return_reg);
      angle_now = wrap_turn(angle_now + ((delta * blend + 32768) >>> 16));
    end
    v.angle = 16'(angle_now);
    v.rotated = rotated;
  endtask

  function automatic row_t sample_row(input logic signed [15:0] x, input logic signed [15:0] y,
                                      input logic [15:0] dt, input logic pause);
    return '{ROW_SAMPLE, REG_DEAD_ZONE, 24'd0, x, y, dt, pause, 1'b0, 17'd0};
  endfunction

  function automatic row_t pinned_row(input logic signed [15:0] x, input logic signed [15:0] y,
                                      input logic [15:0] dt, input logic pause,
                                      input logic signed [15:0] angle, input logic rot);
    return '{ROW_SAMPLE, REG_DEAD_ZONE, 24'd0, x, y, dt, pause, 1'b1, {angle, rot}};
  endfunction

  function automatic row_t reg_row(input logic [1:0] index, input logic [23:0] data);
    return '{ROW_WRITE, index, data, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b0, 17'd0};
  endfunction

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (view_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [23:0] data);
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_DEAD_ZONE: dz_reg = data[14:0];
      REG_MIN_HOLD: hold_reg = data;
      REG_ACTIVE_BLEND: active_reg = data[16:0];
      REG_RETURN_BLEND: return_reg = data[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [15:0] dt, input logic pause,
                             input logic pinned, input view_t pinned_view);
    view_t v;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    stick_x <= x;
    stick_y <= y;
    elapsed_us <= dt;
    paused <= pause;
    do @(posedge clk); while (in_ready !== 1'b1);
    advance_view(x, y, dt, pause, v);
    view_queue.push_back(pinned ? pinned_view : v);
  endtask

  always @(posedge clk) begin : watch_results
    view_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (view_queue.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual angle %0d rotated %0b",
                 $time, view_angle, is_rotated);
        mismatches++;
      end else begin
        want = view_queue.pop_front();
        if (view_angle !== want.angle) begin
          $display("%0t: view_angle mismatch: expected %0d, actual %0d",
                   $time, want.angle, view_angle);
          mismatches++;
        end
        if (is_rotated !== want.rotated) begin
          $display("%0t: is_rotated mismatch: expected %0b, actual %0b",
                   $time, want.rotated, is_rotated);
          mismatches++;
        end
      end
    end
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int left, r_in, len;
    logic pushing, long_steps;
    logic signed [15:0] x, y;
    logic [15:0] dt;
    logic pause;
    logic [23:0] p_dz, p_hold, p_ab, p_rb;

    directed = '{
      pinned_row(16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, 1'b0),
      sample_row(16'sd0, 16'sd16384, 16'd1000, 1'b0),
      sample_row(16'sd16384, 16'sd0, 16'd1000, 1'b0),
      sample_row(16'sd0, -16'sd16384, 16'd1000, 1'b0),
      sample_row(-16'sd16384, 16'sd0, 16'd1000, 1'b1),
      sample_row(-16'sd16384, -16'sd16384, 16'd65535, 1'b0),
      sample_row(16'sd100, -16'sd100, 16'd65535, 1'b1),
      sample_row(16'sd0, 16'sd0, 16'd65535, 1'b0),
      sample_row(16'sd0, 16'sd0, 16'd65535, 1'b0),
      sample_row(16'sd0, 16'sd0, 16'd65535, 1'b0),
      sample_row(-16'sd32768, 16'sd32767, 16'd65535, 1'b1),
      sample_row(16'sd32767, -16'sd32768, 16'd0, 1'b0),
      sample_row(-16'sd1, -16'sd1, 16'd0, 1'b0),
      reg_row(REG_DEAD_ZONE, 24'd0),
      reg_row(REG_ACTIVE_BLEND, 24'd65536),
      pinned_row(16'sd0, 16'sd0, 16'd0, 1'b0, 16'sd0, 1'b1),
      sample_row(16'sd16384, 16'sd16384, 16'd0, 1'b0),
      reg_row(REG_DEAD_ZONE, 24'd16384),
      reg_row(REG_MIN_HOLD, 24'd0),
      reg_row(REG_RETURN_BLEND, 24'd65536),
      sample_row(16'sd16384, 16'sd0, 16'd1, 1'b0),
      sample_row(16'sd16383, 16'sd0, 16'd1, 1'b0),
      reg_row(REG_MIN_HOLD, 24'hFFFFFF),
      reg_row(REG_RETURN_BLEND, 24'd0),
      sample_row(16'sd0, 16'sd16384, 16'd65535, 1'b0),
      sample_row(16'sd0, 16'sd0, 16'd65535, 1'b0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        write_reg(directed[i].index, directed[i].data);
      end else begin
        send_sample(directed[i].x, directed[i].y, directed[i].dt, directed[i].pause,
                    directed[i].pinned, directed[i].view);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      len = 200;
      long_steps = 1'b0;
      case (ph)
        0: begin
          p_dz = DEAD_ZONE_RESET; p_hold = MIN_HOLD_RESET;
          p_ab = ACTIVE_BLEND_RESET; p_rb = RETURN_BLEND_RESET;
        end
        1: begin
          p_dz = 24'd16384; p_hold = 24'd0; p_ab = 24'd65536; p_rb = 24'd65536;
        end
        2: begin
          p_dz = 24'd0; p_hold = 24'hFFFFFF; p_ab = 24'($urandom_range(65536)); p_rb = 24'd0;
          len = 300;
          long_steps = 1'b1;
        end
        3: begin
          p_dz = 24'($urandom_range(16384)); p_hold = 24'($urandom_range(300000));
          p_ab = 24'($urandom_range(65536)); p_rb = 24'($urandom_range(65536));
        end
        4: begin
          p_dz = 24'd4000; p_hold = 24'd100000; p_ab = 24'd32768; p_rb = 24'd1;
          len = 150;
        end
        default: begin
          p_dz = 24'($urandom); p_hold = 24'($urandom);
          p_ab = 24'($urandom); p_rb = 24'($urandom);
          len = 150;
        end
      endcase
      write_reg(REG_DEAD_ZONE, p_dz);
      write_reg(REG_MIN_HOLD, p_hold);
      write_reg(REG_ACTIVE_BLEND, p_ab);
      write_reg(REG_RETURN_BLEND, p_rb);
      send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 86 : 0;
      recv_stall_pct = (ph < 2) ? 86 : (ph < 4) ? 16 : 0;

      // Gestures: the stick is pushed out for a few samples, then let back toward center.
      pushing = 1'b0;
      left = 0;
      for (int n = 0; n < len; n++) begin
        if (n == len / 2) quiesce();
        if (left == 0) begin
          pushing = !pushing;
          left = pushing ? $urandom_range(1, 8) : $urandom_range(1, 16);
        end
        left--;
        r_in = int'(dz_reg) / 2;
        if ($urandom_range(15) == 0) begin
          x = 16'($urandom);
          y = 16'($urandom);
        end else if (pushing) begin
          x = 16'(int'($urandom_range(32768)) - 16384);
          y = 16'(int'($urandom_range(32768)) - 16384);
        end else if ($urandom_range(3) == 0) begin
          x = '0;
          y = '0;
        end else begin
          x = 16'(int'($urandom_range(2 * r_in)) - r_in);
          y = 16'(int'($urandom_range(2 * r_in)) - r_in);
        end
        if (long_steps) begin
          dt = 16'($urandom_range(49152, 65535));
        end else begin
          case ($urandom_range(7))
            0: dt = 16'd0;
            1: dt = 16'hFFFF;
            default: dt = 16'($urandom_range(40000));
          endcase
        end
        pause = ($urandom_range(7) == 0);
        send_sample(x, y, dt, pause, 1'b0, '0);
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== stick_heading_smoother.f =====
hdl/shs_pkg.sv
hdl/shs_sermul.sv
hdl/stick_heading_smoother.sv
bench/testbench.sv
